### src/dbsc_pkg.sv
package dbsc_pkg;

    localparam int WORD_BITS = 64;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_AXIS_AX,
        ST_AXIS_AX_W,
        ST_AXIS_BY,
        ST_AXIS_BY_W,
        ST_AXIS_MUL,
        ST_GCD_DIV,
        ST_GCD_W,
        ST_GCD_MUL,
        ST_CG_DIV,
        ST_CG_W,
        ST_AG_DIV,
        ST_AG_W,
        ST_BG_DIV,
        ST_BG_W,
        ST_INV_DIV,
        ST_INV_W,
        ST_CM_DIV,
        ST_CM_W,
        ST_X0_MUL,
        ST_X0_DIV,
        ST_X0_W,
        ST_Y0_MUL,
        ST_Y0_DIV,
        ST_Y0_W,
        ST_RNG_DIV,
        ST_RNG_W,
        ST_DONE
    } state_t;

    // truncating signed divide request / reply
    typedef struct packed {
        logic  go;
        word_t num;
        word_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quo;
        word_t rem;
    } div_rsp_t;

endpackage

### src/diophantine_box_solution_count.sv
// linear diophantine solution count inside an inclusive box
//
// command channel: drive coef_x, coef_y, rhs and the four box bounds and
// raise start; the beat is taken at a rising edge with start high and busy
// low. busy stays high until the result has been shown.
// result channel: solution_count is valid for exactly one cycle while done
// is high; the receiver cannot stall it, so it must capture it that cycle.
// sequencing: one shared 64-bit restoring divider (one quotient bit a cycle)
// does every division. the euclid loop uses one divide per step (up to about
// 46 steps), then up to eleven further divides fix the base solution and the
// lattice range. an empty box finishes without any divide; one item at a time.
// one shared 33 by 33 bit multiplier makes every product; registered for x0 and y0.
// reset: rst_n clears the sequencer to idle asynchronously; no result is
// pending after reset. the block keeps no state between items.
module diophantine_box_solution_count
#(
    parameter int COEF_BITS  = 32,
    parameter int COORD_BITS = 31
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COEF_BITS-1:0]  coef_x,
    input  logic signed [COEF_BITS-1:0]  coef_y,
    input  logic signed [COEF_BITS-1:0]  rhs,
    input  logic signed [COORD_BITS-1:0] x_low,
    input  logic signed [COORD_BITS-1:0] x_high,
    input  logic signed [COORD_BITS-1:0] y_low,
    input  logic signed [COORD_BITS-1:0] y_high,
    output logic                         done,
    output logic [62:0]                  solution_count
);

    localparam int W  = dbsc_pkg::WORD_BITS;
    localparam int MW = 33;     // every product operand fits in 33 signed bits
    typedef logic signed [W-1:0] sw_t;
    typedef logic signed [MW-1:0] mw_t;

    dbsc_pkg::state_t state_reg, state_next;
    dbsc_pkg::div_req_t dreq;
    dbsc_pkg::div_rsp_t drsp;

    sw_t a_reg, b_reg, c_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    sw_t p_reg, q_reg, s0_reg, s1_reg, dq_reg;
    sw_t ag_reg, bg_reg, cg_reg, dx_reg, inv_reg, cm_reg, x0_reg, y0_reg;
    sw_t lo_reg, hi_reg, prod_reg, xn_reg, yn_reg, res_reg;
    logic [1:0] rk_reg;     // which of the four range bounds is in the divider
    logic ok_reg;

    sw_t a_in, b_in, c_in, x1_in, x2_in, y1_in, y2_in;
    mw_t mul_a, mul_b;
    logic signed [2*MW-1:0] prod_full;
    sw_t prod;
    sw_t dy, e, rng_num, rng_den, t_val;
    logic rng_ceil;

    assign a_in  = sw_t'(coef_x);
    assign b_in  = sw_t'(coef_y);
    assign c_in  = sw_t'(rhs);
    assign x1_in = sw_t'(x_low);
    assign x2_in = sw_t'(x_high);
    assign y1_in = sw_t'(y_low);
    assign y2_in = sw_t'(y_high);

    dbsc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // lattice step along y, and the four range bounds in order
    assign dy = (bg_reg > 0) ? -ag_reg : ag_reg;
    assign e  = (dy > 0) ? dy : -dy;

    always_comb
    begin
        rng_num  = '0;
        rng_den  = dx_reg;
        rng_ceil = 1'b0;
        case (rk_reg)
            2'd0:
            begin
                rng_num = x1_reg - x0_reg; rng_den = dx_reg; rng_ceil = 1'b1;
            end
            2'd1:
            begin
                rng_num = x2_reg - x0_reg; rng_den = dx_reg; rng_ceil = 1'b0;
            end
            2'd2:
            begin
                rng_num  = (dy > 0) ? y1_reg - y0_reg : y0_reg - y2_reg;
                rng_den  = e;
                rng_ceil = 1'b1;
            end
            default:
            begin
                rng_num  = (dy > 0) ? y2_reg - y0_reg : y0_reg - y1_reg;
                rng_den  = e;
                rng_ceil = 1'b0;
            end
        endcase
    end

    // floor or ceil from truncated quotient (divisor positive)
    always_comb
    begin
        t_val = drsp.quo;
        if (drsp.rem != 0)
        begin
            if (rng_ceil && !rng_num[W-1])
                t_val = drsp.quo + 1;
            else if (!rng_ceil && rng_num[W-1])
                t_val = drsp.quo - 1;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = mw_t'(xn_reg);
        mul_b = mw_t'(yn_reg);
        case (state_reg)
            dbsc_pkg::ST_GCD_MUL:
            begin
                mul_a = mw_t'(dq_reg); mul_b = mw_t'(s1_reg);
            end
            dbsc_pkg::ST_X0_MUL:
            begin
                mul_a = mw_t'(cm_reg); mul_b = mw_t'(inv_reg);
            end
            dbsc_pkg::ST_Y0_MUL:
            begin
                mul_a = mw_t'(ag_reg); mul_b = mw_t'(x0_reg);
            end
            default:
            begin
                mul_a = mw_t'(xn_reg); mul_b = mw_t'(yn_reg);
            end
        endcase
    end
    assign prod_full = mul_a * mul_b;
    assign prod      = sw_t'(prod_full);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dbsc_pkg::ST_IDLE:     if (start) state_next = dbsc_pkg::ST_CHECK;
            dbsc_pkg::ST_CHECK:
            begin
                if (x1_reg > x2_reg || y1_reg > y2_reg)
                    state_next = dbsc_pkg::ST_DONE;
                else if (a_reg == 0 || b_reg == 0)
                    state_next = dbsc_pkg::ST_AXIS_AX;
                else
                    state_next = dbsc_pkg::ST_GCD_DIV;
            end
            dbsc_pkg::ST_AXIS_AX:
                state_next = (a_reg != 0) ? dbsc_pkg::ST_AXIS_AX_W : dbsc_pkg::ST_AXIS_BY;
            dbsc_pkg::ST_AXIS_AX_W: if (drsp.done) state_next = dbsc_pkg::ST_AXIS_BY;
            dbsc_pkg::ST_AXIS_BY:
                state_next = (b_reg != 0) ? dbsc_pkg::ST_AXIS_BY_W : dbsc_pkg::ST_AXIS_MUL;
            dbsc_pkg::ST_AXIS_BY_W: if (drsp.done) state_next = dbsc_pkg::ST_AXIS_MUL;
            dbsc_pkg::ST_AXIS_MUL: state_next = dbsc_pkg::ST_DONE;
            dbsc_pkg::ST_GCD_DIV:
                state_next = (q_reg == 0) ? dbsc_pkg::ST_CG_DIV : dbsc_pkg::ST_GCD_W;
            dbsc_pkg::ST_GCD_W:    if (drsp.done) state_next = dbsc_pkg::ST_GCD_MUL;
            dbsc_pkg::ST_GCD_MUL:  state_next = dbsc_pkg::ST_GCD_DIV;
            dbsc_pkg::ST_CG_DIV:   state_next = dbsc_pkg::ST_CG_W;
            dbsc_pkg::ST_CG_W:
                if (drsp.done)
                    state_next = (drsp.rem != 0) ? dbsc_pkg::ST_DONE : dbsc_pkg::ST_AG_DIV;
            dbsc_pkg::ST_AG_DIV:   state_next = dbsc_pkg::ST_AG_W;
            dbsc_pkg::ST_AG_W:     if (drsp.done) state_next = dbsc_pkg::ST_BG_DIV;
            dbsc_pkg::ST_BG_DIV:   state_next = dbsc_pkg::ST_BG_W;
            dbsc_pkg::ST_BG_W:
                if (drsp.done)
                    state_next = (drsp.quo == 1 || drsp.quo == -1) ?
                                 dbsc_pkg::ST_Y0_MUL : dbsc_pkg::ST_INV_DIV;
            dbsc_pkg::ST_INV_DIV:  state_next = dbsc_pkg::ST_INV_W;
            dbsc_pkg::ST_INV_W:    if (drsp.done) state_next = dbsc_pkg::ST_CM_DIV;
            dbsc_pkg::ST_CM_DIV:   state_next = dbsc_pkg::ST_CM_W;
            dbsc_pkg::ST_CM_W:     if (drsp.done) state_next = dbsc_pkg::ST_X0_MUL;
            dbsc_pkg::ST_X0_MUL:   state_next = dbsc_pkg::ST_X0_DIV;
            dbsc_pkg::ST_X0_DIV:   state_next = dbsc_pkg::ST_X0_W;
            dbsc_pkg::ST_X0_W:     if (drsp.done) state_next = dbsc_pkg::ST_Y0_MUL;
            dbsc_pkg::ST_Y0_MUL:   state_next = dbsc_pkg::ST_Y0_DIV;
            dbsc_pkg::ST_Y0_DIV:   state_next = dbsc_pkg::ST_Y0_W;
            dbsc_pkg::ST_Y0_W:     if (drsp.done) state_next = dbsc_pkg::ST_RNG_DIV;
            dbsc_pkg::ST_RNG_DIV:  state_next = dbsc_pkg::ST_RNG_W;
            dbsc_pkg::ST_RNG_W:
                if (drsp.done)
                    state_next = (rk_reg == 2'd3) ? dbsc_pkg::ST_DONE : dbsc_pkg::ST_RNG_DIV;
            dbsc_pkg::ST_DONE:     state_next = dbsc_pkg::ST_IDLE;
            default:               state_next = dbsc_pkg::ST_IDLE;
        endcase
    end

    // divider requests
    always_comb
    begin
        dreq.go  = 1'b0;
        dreq.num = '0;
        dreq.den = sw_t'(1);
        case (state_reg)
            dbsc_pkg::ST_AXIS_AX:
            begin
                dreq.go = (a_reg != 0); dreq.num = c_reg; dreq.den = a_reg;
            end
            dbsc_pkg::ST_AXIS_BY:
            begin
                dreq.go = (b_reg != 0); dreq.num = c_reg; dreq.den = b_reg;
            end
            dbsc_pkg::ST_GCD_DIV:
            begin
                dreq.go = (q_reg != 0); dreq.num = p_reg; dreq.den = q_reg;
            end
            dbsc_pkg::ST_CG_DIV:
            begin
                dreq.go = 1'b1; dreq.num = c_reg; dreq.den = p_reg;
            end
            dbsc_pkg::ST_AG_DIV:
            begin
                dreq.go = 1'b1; dreq.num = a_reg; dreq.den = p_reg;
            end
            dbsc_pkg::ST_BG_DIV:
            begin
                dreq.go = 1'b1; dreq.num = b_reg; dreq.den = p_reg;
            end
            dbsc_pkg::ST_INV_DIV:
            begin
                dreq.go  = 1'b1;
                dreq.num = (a_reg < 0) ? -s0_reg : s0_reg;
                dreq.den = dx_reg;
            end
            dbsc_pkg::ST_CM_DIV:
            begin
                dreq.go = 1'b1; dreq.num = cg_reg; dreq.den = dx_reg;
            end
            dbsc_pkg::ST_X0_DIV:
            begin
                dreq.go = 1'b1; dreq.num = prod_reg; dreq.den = dx_reg;
            end
            dbsc_pkg::ST_Y0_DIV:
            begin
                dreq.go = 1'b1; dreq.num = cg_reg - prod_reg; dreq.den = bg_reg;
            end
            dbsc_pkg::ST_RNG_DIV:
            begin
                dreq.go = 1'b1; dreq.num = rng_num; dreq.den = rng_den;
            end
            default:
            begin
                dreq.go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dbsc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        case (state_reg)
            dbsc_pkg::ST_IDLE:
            begin
                a_reg  <= a_in;  b_reg  <= b_in;  c_reg  <= c_in;
                x1_reg <= x1_in; x2_reg <= x2_in; y1_reg <= y1_in; y2_reg <= y2_in;
                p_reg  <= (a_in < 0) ? -a_in : a_in;
                q_reg  <= (b_in < 0) ? -b_in : b_in;
                s0_reg <= sw_t'(1);
                s1_reg <= '0;
                res_reg <= '0;
                rk_reg <= 2'd0;
                ok_reg <= 1'b1;
            end
            dbsc_pkg::ST_CHECK:
            begin
                xn_reg <= x2_reg - x1_reg + 1;
                yn_reg <= y2_reg - y1_reg + 1;
                if (a_reg == 0 && b_reg == 0 && c_reg != 0)
                    ok_reg <= 1'b0;
            end
            dbsc_pkg::ST_AXIS_AX_W:
                if (drsp.done)
                    xn_reg <= (drsp.rem == 0 && x1_reg <= drsp.quo && drsp.quo <= x2_reg)
                              ? sw_t'(1) : '0;
            dbsc_pkg::ST_AXIS_BY_W:
                if (drsp.done)
                    yn_reg <= (drsp.rem == 0 && y1_reg <= drsp.quo && drsp.quo <= y2_reg)
                              ? sw_t'(1) : '0;
            dbsc_pkg::ST_AXIS_MUL:
                res_reg <= ok_reg ? prod : '0;
            dbsc_pkg::ST_GCD_W:
                if (drsp.done)
                begin
                    dq_reg <= drsp.quo;
                    p_reg  <= q_reg;
                    q_reg  <= drsp.rem;
                end
            dbsc_pkg::ST_GCD_MUL:
            begin
                s0_reg <= s1_reg;
                s1_reg <= s0_reg - prod;
            end
            dbsc_pkg::ST_CG_W:
                if (drsp.done) cg_reg <= drsp.quo;
            dbsc_pkg::ST_AG_W:
                if (drsp.done) ag_reg <= drsp.quo;
            dbsc_pkg::ST_BG_W:
                if (drsp.done)
                begin
                    bg_reg <= drsp.quo;
                    dx_reg <= drsp.quo[W-1] ? -drsp.quo : drsp.quo;
                    x0_reg <= '0;
                end
            dbsc_pkg::ST_INV_W:
                if (drsp.done) inv_reg <= drsp.rem[W-1] ? drsp.rem + dx_reg : drsp.rem;
            dbsc_pkg::ST_CM_W:
                if (drsp.done) cm_reg <= drsp.rem[W-1] ? drsp.rem + dx_reg : drsp.rem;
            dbsc_pkg::ST_X0_W:
                if (drsp.done) x0_reg <= drsp.rem;
            dbsc_pkg::ST_Y0_W:
                if (drsp.done) y0_reg <= drsp.quo;
            dbsc_pkg::ST_RNG_W:
                if (drsp.done)
                begin
                    rk_reg <= rk_reg + 2'd1;
                    case (rk_reg)
                        2'd0: lo_reg <= t_val;
                        2'd1: hi_reg <= t_val;
                        2'd2: if (t_val > lo_reg) lo_reg <= t_val;
                        default:
                        begin
                            if (t_val < hi_reg)
                                res_reg <= (t_val < lo_reg) ? '0 : t_val - lo_reg + 1;
                            else
                                res_reg <= (hi_reg < lo_reg) ? '0 : hi_reg - lo_reg + 1;
                        end
                    endcase
                end
            default:
            begin
            end
        endcase
    end

    assign busy           = (state_reg != dbsc_pkg::ST_IDLE);
    assign done           = (state_reg == dbsc_pkg::ST_DONE);
    assign solution_count = res_reg[62:0];

endmodule

### src/dbsc_div.sv
module dbsc_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  dbsc_pkg::div_req_t req,
    output dbsc_pkg::div_rsp_t rsp
);

    localparam int W = dbsc_pkg::WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic          nneg_reg, nneg_next;
    logic          qneg_reg, qneg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        nneg_next = nneg_reg;
        qneg_next = qneg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.go)
        begin
            // magnitudes, restoring shift-subtract one bit a cycle
            quo_next  = req.num[W-1] ? W'(-req.num) : W'(req.num);
            den_next  = req.den[W-1] ? W'(-req.den) : W'(req.den);
            rem_next  = '0;
            nneg_next = req.num[W-1];
            qneg_next = req.num[W-1] ^ req.den[W-1];
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[W-1:0], quo_reg[W-1]} - {1'b0, den_reg};
            if (!trial[W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-1:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        nneg_reg <= nneg_next;
        qneg_reg <= qneg_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.quo  = qneg_reg ? -quo_reg : quo_reg;
        rsp.rem  = nneg_reg ? -rem_reg[W-1:0] : rem_reg[W-1:0];
    end

endmodule

### bench/tb_diophantine_box_solution_count.sv
module tb_diophantine_box_solution_count;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COEF_W   = 32;
    localparam int COORD_W  = 31;
    localparam int STALL_MAX = 20000;   // idle cycles before giving up

    // one command beat as driven onto the block
    typedef struct {
        logic signed [COEF_W-1:0]  cx;
        logic signed [COEF_W-1:0]  cy;
        logic signed [COEF_W-1:0]  c;
        logic signed [COORD_W-1:0] xl;
        logic signed [COORD_W-1:0] xh;
        logic signed [COORD_W-1:0] yl;
        logic signed [COORD_W-1:0] yh;
    } box_cmd_t;

    // floor, ceil, modulo and magnitude helpers on 64-bit signed values
    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint div_ceil(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n > 0)
            q++;
        return q;
    endfunction

    function automatic longint wrap_mod(longint n, longint m);
        longint r;
        r = n % m;
        return (r < 0) ? r + m : r;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // exact count of lattice points on a*x + b*y = c inside the box
    function automatic logic [62:0] lattice_count(box_cmd_t cmd);
        longint a, b, c, x1, x2, y1, y2;
        longint p, q, s0, s1, sn, d, r, g;
        longint aa, bb, cc, dx, dy, x0, y0, lo, hi, t, xn, yn, inv, e;
        a = cmd.cx; b = cmd.cy; c = cmd.c;
        x1 = cmd.xl; x2 = cmd.xh; y1 = cmd.yl; y2 = cmd.yh;
        if (x1 > x2 || y1 > y2)
            return '0;
        if (a == 0 || b == 0)
        begin
            xn = x2 - x1 + 1;
            yn = y2 - y1 + 1;
            if (a == 0 && b == 0 && c != 0)
                return '0;
            if (a != 0)
                xn = (c % a == 0 && x1 <= c / a && c / a <= x2) ? 1 : 0;
            if (b != 0)
                yn = (c % b == 0 && y1 <= c / b && c / b <= y2) ? 1 : 0;
            return 63'(xn * yn);
        end
        p = mag(a); q = mag(b); s0 = 1; s1 = 0;
        while (q != 0)
        begin
            d = p / q; r = p % q; sn = s0 - d * s1;
            p = q; q = r; s0 = s1; s1 = sn;
        end
        g = p;
        if (c % g != 0)
            return '0;
        aa = a / g; bb = b / g; cc = c / g;
        dx = mag(bb);
        if (dx == 1)
            x0 = 0;
        else
        begin
            inv = wrap_mod(a < 0 ? -s0 : s0, dx);
            x0 = (wrap_mod(cc, dx) * inv) % dx;
        end
        y0 = (cc - aa * x0) / bb;
        dy = (bb > 0) ? -aa : aa;
        lo = div_ceil(x1 - x0, dx);
        hi = div_floor(x2 - x0, dx);
        if (dy > 0)
        begin
            t = div_ceil(y1 - y0, dy);  if (t > lo) lo = t;
            t = div_floor(y2 - y0, dy); if (t < hi) hi = t;
        end
        else
        begin
            e = -dy;
            t = div_ceil(y0 - y2, e);  if (t > lo) lo = t;
            t = div_floor(y0 - y1, e); if (t < hi) hi = t;
        end
        if (hi < lo)
            return '0;
        return 63'(hi - lo + 1);
    endfunction

    // holds expected counts in issue order and checks returned ones
    class count_scoreboard;
        logic [62:0] pending[$];
        int errors;
        int checked;

        function void note_cmd(box_cmd_t cmd);
            pending.push_back(lattice_count(cmd));
        endfunction

        function void check_count(logic [62:0] got);
            logic [62:0] want;
            if (pending.size() == 0)
            begin
                $error("solution_count: unexpected result %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("solution_count: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [COEF_W-1:0]    coef_x, coef_y, rhs;
    logic signed [COORD_W-1:0]   x_low, x_high, y_low, y_high;
    logic                        done;
    logic [62:0]                 solution_count;

    diophantine_box_solution_count dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .coef_x         (coef_x),
        .coef_y         (coef_y),
        .rhs            (rhs),
        .x_low          (x_low),
        .x_high         (x_high),
        .y_low          (y_low),
        .y_high         (y_high),
        .done           (done),
        .solution_count (solution_count)
    );

    count_scoreboard board;
    box_cmd_t        directed_cmds[$];
    int              idle_cycles;
    int              cmds_sent;
    bit              quiet_stretch;   // no sender gaps while set
    bit              timed_out;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // results cannot be stalled: take every done beat
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_count(solution_count);
    end

    // watchdog: count cycles in which no beat moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic box_cmd_t make_cmd(longint cx, longint cy, longint c,
                                          longint xl, longint xh,
                                          longint yl, longint yh);
        box_cmd_t cmd;
        cmd.cx = cx[COEF_W-1:0];  cmd.cy = cy[COEF_W-1:0];  cmd.c = c[COEF_W-1:0];
        cmd.xl = xl[COORD_W-1:0]; cmd.xh = xh[COORD_W-1:0];
        cmd.yl = yl[COORD_W-1:0]; cmd.yh = yh[COORD_W-1:0];
        return cmd;
    endfunction

    // mostly small signed values, keeps the lattice dense enough to hit the box; sometimes zero, wide or extreme
    function automatic longint pick_coef();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return longint'($signed($urandom()));
            2:       return longint'($signed($urandom())) >>> $urandom_range(0, 24);
            3:       return $urandom_range(0, 1) ? 2147483647 : -2147483648;
            default: return longint'($urandom_range(0, 60)) - 30;
        endcase
    endfunction

    function automatic box_cmd_t random_cmd();
        longint cx, cy, c, xl, xh, yl, yh, span;
        cx = pick_coef();
        cy = pick_coef();
        case ($urandom_range(0, 5))
            0:       c = longint'($signed($urandom()));
            1:       c = 0;
            default: c = longint'($urandom_range(0, 2000)) - 1000;
        endcase
        // mostly well-formed boxes, occasionally inverted or huge
        span = $urandom_range(0, 3) == 0 ? 64'd1073741823 : $urandom_range(0, 5000);
        xl = longint'($signed({$urandom(), 1'b0}) >>> 1) >>> $urandom_range(0, 30);
        yl = longint'($signed({$urandom(), 1'b0}) >>> 1) >>> $urandom_range(0, 30);
        if ($urandom_range(0, 3) != 0)
        begin
            xl = longint'($urandom_range(0, 2000)) - 1000;
            yl = longint'($urandom_range(0, 2000)) - 1000;
        end
        xh = xl + span;
        yh = yl + longint'($urandom_range(0, span > 5000 ? 5000 : span));
        if (xh > 1073741823) xh = 1073741823;
        if (yh > 1073741823) yh = 1073741823;
        if ($urandom_range(0, 15) == 0)
        begin
            xl = longint'($signed({$urandom(), 1'b0}) >>> 1);
            xh = longint'($signed({$urandom(), 1'b0}) >>> 1);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            yl = longint'($signed({$urandom(), 1'b0}) >>> 1);
            yh = longint'($signed({$urandom(), 1'b0}) >>> 1);
        end
        return make_cmd(cx, cy, c, xl, xh, yl, yh);
    endfunction

    // present one beat and hold it until the block takes it
    task automatic send_cmd(box_cmd_t cmd);
        while (!quiet_stretch && $urandom_range(0, 99) < 18)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        coef_x <= cmd.cx; coef_y <= cmd.cy; rhs <= cmd.c;
        x_low  <= cmd.xl; x_high <= cmd.xh;
        y_low  <= cmd.yl; y_high <= cmd.yh;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_cmd(cmd);
        cmds_sent++;
    endtask

    localparam longint CMIN = -2147483648;
    localparam longint CMAX = 2147483647;
    localparam longint BMIN = -1073741824;
    localparam longint BMAX = 1073741823;

    initial
    begin
        box_cmd_t cmd;
        board         = new();
        idle_cycles   = 0;
        cmds_sent     = 0;
        quiet_stretch = 1'b0;
        timed_out     = 1'b0;
        rst_n  = 1'b0;
        start  = 1'b0;
        coef_x = '0; coef_y = '0; rhs = '0;
        x_low  = '0; x_high = '0; y_low = '0; y_high = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty box on either axis
        directed_cmds.push_back(make_cmd(3, 5, 7, 10, 9, 0, 100));
        directed_cmds.push_back(make_cmd(3, 5, 7, 0, 100, BMAX, BMIN));
        // both coefficients zero: full area, then nothing
        directed_cmds.push_back(make_cmd(0, 0, 0, BMIN, BMAX, BMIN, BMAX));
        directed_cmds.push_back(make_cmd(0, 0, 1, BMIN, BMAX, BMIN, BMAX));
        directed_cmds.push_back(make_cmd(0, 0, CMIN, 0, 0, 0, 0));
        // one coefficient zero
        directed_cmds.push_back(make_cmd(0, 4, 12, -5, 5, 0, 10));
        directed_cmds.push_back(make_cmd(0, 4, 13, -5, 5, 0, 10));
        directed_cmds.push_back(make_cmd(-7, 0, 21, -3, -3, BMIN, BMAX));
        directed_cmds.push_back(make_cmd(CMIN, 0, CMIN, 1, 1, 0, 0));
        // gcd does not divide rhs
        directed_cmds.push_back(make_cmd(6, 9, 5, -100, 100, -100, 100));
        // general case, all sign mixes
        directed_cmds.push_back(make_cmd(3, 5, 7, -100, 100, -100, 100));
        directed_cmds.push_back(make_cmd(-3, 5, 7, -100, 100, -100, 100));
        directed_cmds.push_back(make_cmd(3, -5, -7, -100, 100, -100, 100));
        directed_cmds.push_back(make_cmd(-3, -5, 7, -100, 100, -100, 100));
        directed_cmds.push_back(make_cmd(1, 1, 0, BMIN, BMAX, BMIN, BMAX));
        directed_cmds.push_back(make_cmd(1, -1, 0, BMIN, BMAX, BMIN, BMAX));
        // extreme coefficients and rhs
        directed_cmds.push_back(make_cmd(CMAX, CMIN, CMAX, BMIN, BMAX, BMIN, BMAX));
        directed_cmds.push_back(make_cmd(CMIN, CMIN, CMIN, BMIN, BMAX, BMIN, BMAX));
        directed_cmds.push_back(make_cmd(CMAX, CMAX - 1, -1, BMIN, BMAX, BMIN, BMAX));
        // fibonacci pair: longest euclid chain
        directed_cmds.push_back(make_cmd(1836311903, 1134903170, 1, BMIN, BMAX, BMIN, BMAX));
        directed_cmds.push_back(make_cmd(-1, -1, -1, -1, -1, -1, -1));
        directed_cmds.push_back(make_cmd(2, 2, 4, 2, 2, 0, 0));

        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i]);

        // random part; one stretch runs with no sender gaps
        for (int n = 0; n < 240; n++)
        begin
            quiet_stretch = (n >= 80 && n < 130);
            cmd = random_cmd();
            send_cmd(cmd);
        end
        quiet_stretch = 1'b0;
        start <= 1'b0;

        // drain, then keep watching for a stray beat
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("sent %0d commands, checked %0d counts (empty boxes, zero coefficients,",
                 cmds_sent, board.checked);
        $display("no-solution cases, extreme coefficients and random boxes)");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
